// ----- design/microprogrammed_datapath_step_unit_defines.svh -----
`ifndef MICROPROGRAMMED_DATAPATH_STEP_UNIT_DEFINES_SVH
`define MICROPROGRAMMED_DATAPATH_STEP_UNIT_DEFINES_SVH

// Implication checked in the same cycle, disabled during reset.
`define MDSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define MDSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mdsu_pkg.sv -----
`default_nettype none

package mdsu_pkg;

	localparam int DATA_W = 32;
	localparam int MBR_W = 8;
	localparam int NUM_REGS = 10;
	localparam int MASK_W = 9;

	localparam int IN_USER_W = 2;
	localparam int IN_DATA_W = 64;
	localparam int OUT_USER_W = 1;
	localparam int OUT_DATA_W = 168;

	localparam logic [1:0] OP_EXEC = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] ALU_AND = 2'd0;
	localparam logic [1:0] ALU_OR = 2'd1;
	localparam logic [1:0] ALU_NOTB = 2'd2;
	localparam logic [1:0] ALU_ADD = 2'd3;

	localparam logic [3:0] BSEL_MDR = 4'd0;
	localparam logic [3:0] BSEL_PC = 4'd1;
	localparam logic [3:0] BSEL_MBR_S = 4'd2;
	localparam logic [3:0] BSEL_MBR_U = 4'd3;
	localparam logic [3:0] BSEL_SP = 4'd4;
	localparam logic [3:0] BSEL_LV = 4'd5;
	localparam logic [3:0] BSEL_CPP = 4'd6;
	localparam logic [3:0] BSEL_TOS = 4'd7;
	localparam logic [3:0] BSEL_OPC = 4'd8;

	localparam logic [3:0] REG_MAR = 4'd0;
	localparam logic [3:0] REG_MDR = 4'd1;
	localparam logic [3:0] REG_PC = 4'd2;
	localparam logic [3:0] REG_SP = 4'd3;
	localparam logic [3:0] REG_LV = 4'd4;
	localparam logic [3:0] REG_CPP = 4'd5;
	localparam logic [3:0] REG_TOS = 4'd6;
	localparam logic [3:0] REG_OPC = 4'd7;
	localparam logic [3:0] REG_H = 4'd8;
	localparam logic [3:0] REG_MBR = 4'd9;

	typedef struct packed {
		logic [1:0] op;
		logic shift_left8;
		logic shift_right1;
		logic [1:0] alu_func;
		logic enable_a;
		logic enable_b;
		logic invert_a;
		logic increment;
		logic [MASK_W-1:0] c_mask;
		logic [3:0] b_select;
		logic [3:0] reg_index;
		logic signed [DATA_W-1:0] load_value;
	} item_t;

	typedef struct packed {
		logic status;
		logic signed [DATA_W-1:0] a_value;
		logic signed [DATA_W-1:0] b_value;
		logic signed [DATA_W-1:0] alu_result;
		logic signed [DATA_W-1:0] shift_result;
		logic flag_n;
		logic flag_z;
		logic flag_carry;
		logic signed [DATA_W-1:0] read_value;
	} result_t;

	typedef struct packed {
		logic [DATA_W-1:0] h;
		logic [DATA_W-1:0] opc;
		logic [DATA_W-1:0] tos;
		logic [DATA_W-1:0] cpp;
		logic [DATA_W-1:0] lv;
		logic [DATA_W-1:0] sp;
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] mdr;
		logic [DATA_W-1:0] mar;
		logic [MBR_W-1:0] mbr;
	} regs_t;

	// One enable per register, indexed like reg_index.
	typedef struct packed {
		logic [NUM_REGS-1:0] en;
		logic [DATA_W-1:0] value;
	} reg_wr_t;

	function automatic item_t unpack_item(input logic [IN_USER_W-1:0] user,
		input logic [IN_DATA_W-1:0] data);
		item_t it;
		it.op = user;
		it.shift_left8 = data[0];
		it.shift_right1 = data[1];
		it.alu_func = data[3:2];
		it.enable_a = data[4];
		it.enable_b = data[5];
		it.invert_a = data[6];
		it.increment = data[7];
		it.c_mask = data[16:8];
		it.b_select = data[20:17];
		it.reg_index = data[24:21];
		it.load_value = data[56:25];
		return it;
	endfunction

	function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
		logic [OUT_DATA_W-1:0] d;
		d = '0;
		d[31:0] = r.a_value;
		d[63:32] = r.b_value;
		d[95:64] = r.alu_result;
		d[127:96] = r.shift_result;
		d[128] = r.flag_n;
		d[129] = r.flag_z;
		d[130] = r.flag_carry;
		d[162:131] = r.read_value;
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- design/mdsu_regfile.sv -----
`default_nettype none

module mdsu_regfile (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	input wire mdsu_pkg::reg_wr_t wr,
	output mdsu_pkg::regs_t regs
);
	import mdsu_pkg::*;

	regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_valid) begin
			if (wr.en[REG_MAR]) regs_q.mar <= wr.value;
			if (wr.en[REG_MDR]) regs_q.mdr <= wr.value;
			if (wr.en[REG_PC]) regs_q.pc <= wr.value;
			if (wr.en[REG_SP]) regs_q.sp <= wr.value;
			if (wr.en[REG_LV]) regs_q.lv <= wr.value;
			if (wr.en[REG_CPP]) regs_q.cpp <= wr.value;
			if (wr.en[REG_TOS]) regs_q.tos <= wr.value;
			if (wr.en[REG_OPC]) regs_q.opc <= wr.value;
			if (wr.en[REG_H]) regs_q.h <= wr.value;
			if (wr.en[REG_MBR]) regs_q.mbr <= wr.value[MBR_W-1:0];
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ----- design/mdsu_exec.sv -----
`default_nettype none

module mdsu_exec (
	input wire mdsu_pkg::item_t item,
	input wire mdsu_pkg::regs_t regs,
	output mdsu_pkg::result_t res,
	output mdsu_pkg::reg_wr_t wr
);
	import mdsu_pkg::*;

	logic [DATA_W-1:0] b_bus;
	logic [DATA_W-1:0] ain;
	logic [DATA_W-1:0] bin;
	logic [DATA_W:0] sum;
	logic [DATA_W-1:0] inc_ext;
	logic [DATA_W-1:0] alu_s;
	logic carry;
	logic [DATA_W-1:0] sd;
	logic [DATA_W-1:0] rd;

	always_comb begin
		unique case (item.b_select)
			BSEL_MDR: b_bus = regs.mdr;
			BSEL_PC: b_bus = regs.pc;
			BSEL_MBR_S: b_bus = {{(DATA_W-MBR_W){regs.mbr[MBR_W-1]}}, regs.mbr};
			BSEL_MBR_U: b_bus = {{(DATA_W-MBR_W){1'b0}}, regs.mbr};
			BSEL_SP: b_bus = regs.sp;
			BSEL_LV: b_bus = regs.lv;
			BSEL_CPP: b_bus = regs.cpp;
			BSEL_TOS: b_bus = regs.tos;
			BSEL_OPC: b_bus = regs.opc;
			default: b_bus = '0;
		endcase
	end

	always_comb begin
		unique case (item.reg_index)
			REG_MAR: rd = regs.mar;
			REG_MDR: rd = regs.mdr;
			REG_PC: rd = regs.pc;
			REG_SP: rd = regs.sp;
			REG_LV: rd = regs.lv;
			REG_CPP: rd = regs.cpp;
			REG_TOS: rd = regs.tos;
			REG_OPC: rd = regs.opc;
			REG_H: rd = regs.h;
			REG_MBR: rd = {{(DATA_W-MBR_W){1'b0}}, regs.mbr};
			default: rd = '0;
		endcase
	end

	always_comb begin
		ain = item.enable_a ? regs.h : '0;
		if (item.invert_a) ain = ~ain;
		bin = item.enable_b ? b_bus : '0;
		inc_ext = {{(DATA_W-1){1'b0}}, item.increment};
		sum = {1'b0, ain} + {1'b0, bin} + {1'b0, inc_ext};
		carry = 1'b0;
		case (item.alu_func)
			ALU_AND: alu_s = (ain & bin) + inc_ext;
			ALU_OR: alu_s = (ain | bin) + inc_ext;
			ALU_NOTB: alu_s = ~bin + inc_ext;
			default: begin
				alu_s = sum[DATA_W-1:0];
				carry = sum[DATA_W];
			end
		endcase
		if (item.shift_left8) sd = {alu_s[DATA_W-9:0], 8'h00};
		else if (item.shift_right1) sd = {alu_s[DATA_W-1], alu_s[DATA_W-1:1]};
		else sd = alu_s;
	end

	always_comb begin
		res = '0;
		wr = '0;
		unique case (item.op)
			OP_EXEC: begin
				if (item.shift_left8 && item.shift_right1) begin
					res.status = 1'b1;
				end else begin
					res.a_value = regs.h;
					res.b_value = b_bus;
					res.alu_result = alu_s;
					res.shift_result = sd;
					res.flag_n = sd[DATA_W-1];
					res.flag_z = (sd == '0);
					res.flag_carry = carry;
					wr.en = {1'b0, item.c_mask};
					wr.value = sd;
				end
			end
			OP_LOAD: begin
				// Indexes past MBR select nothing, so the preload is dropped.
				if (item.reg_index <= REG_MBR) wr.en[item.reg_index] = 1'b1;
				wr.value = item.load_value;
			end
			OP_READ: res.read_value = rd;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/microprogrammed_datapath_step_unit.sv -----
// An item is held in the input register; its result is stored in the output register.
// One item per cycle unless the output stalls; the register file is written as an item
// leaves the input register, so the next item reads the updated registers with no bubble.
// Reset (arst_n low) clears all ten datapath registers to zero and empties both the
// input register and the output register.
`default_nettype none

module microprogrammed_datapath_step_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// shift_left8, shift_right1, alu_func, enable_a, enable_b, invert_a, increment,
	// c_mask, b_select, reg_index, load_value, zero padding
	input wire logic [mdsu_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// op
	input wire logic [mdsu_pkg::IN_USER_W-1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// a_value, b_value, alu_result, shift_result, flag_n, flag_z, flag_carry,
	// read_value, zero padding
	output logic [mdsu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [mdsu_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import mdsu_pkg::*;

	`include "microprogrammed_datapath_step_unit_defines.svh"

	logic valid_s1;
	item_t item_s1;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;
	logic advance;
	logic commit;
	regs_t regs;
	result_t res;
	reg_wr_t wr;

	assign advance = !out_valid_q || m_axis_tready;
	assign commit = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= unpack_item(s_axis_tuser, s_axis_tdata);
		end
	end

	mdsu_exec u_exec (
		.item(item_s1),
		.regs(regs),
		.res(res),
		.wr(wr)
	);

	mdsu_regfile u_regfile (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(commit),
		.wr(wr),
		.regs(regs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= pack_result(res);
			out_user_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

	`MDSU_ASSERT_NOW(a_flagged_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "flagged result carries nonzero data")
	`MDSU_ASSERT_NEXT(a_regs_hold, clk, arst_n, !commit, $stable(regs), "register file changed without a committed item")
	`MDSU_ASSERT_NOW(a_flagged_no_write, clk, arst_n, valid_s1 && res.status, wr.en == '0, "invalid control item writes a register")
	`MDSU_ASSERT_NEXT(a_commit_shows, clk, arst_n, commit, m_axis_tvalid, "committed item did not reach the output register")

endmodule

`default_nettype wire

// ----- test/microprogrammed_datapath_step_unit_test.sv -----
`timescale 1ns / 100ps

module microprogrammed_datapath_step_unit_test;
	import mdsu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 750;
	localparam int IDLE_PERCENT = 31;

	// Codes the block has no name for: op 3, an index past the last register and a B select past the last source.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [3:0] REG_NONE = 4'd15;
	localparam logic [3:0] BSEL_NONE = 4'd15;

	typedef struct {
		item_t it;
		bit known;
		result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic [IN_USER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// Shadow copy of the register file: MAR..H indexed like reg_index, MBR apart.
	logic [DATA_W-1:0] dp_regs [0:MASK_W-1];
	logic [MBR_W-1:0] dp_mbr;

	result_t expected_results[$];
	stim_row_t stim_rows[$];
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;

	microprogrammed_datapath_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [IN_DATA_W-1:0] item_data(input item_t it);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[0] = it.shift_left8;
		d[1] = it.shift_right1;
		d[3:2] = it.alu_func;
		d[4] = it.enable_a;
		d[5] = it.enable_b;
		d[6] = it.invert_a;
		d[7] = it.increment;
		d[16:8] = it.c_mask;
		d[20:17] = it.b_select;
		d[24:21] = it.reg_index;
		d[56:25] = it.load_value;
		return d;
	endfunction

	function automatic logic [DATA_W-1:0] b_source(input logic [3:0] sel);
		case (sel)
			BSEL_MDR: return dp_regs[REG_MDR];
			BSEL_PC: return dp_regs[REG_PC];
			BSEL_MBR_S: return {{(DATA_W-MBR_W){dp_mbr[MBR_W-1]}}, dp_mbr};
			BSEL_MBR_U: return {{(DATA_W-MBR_W){1'b0}}, dp_mbr};
			BSEL_SP: return dp_regs[REG_SP];
			BSEL_LV: return dp_regs[REG_LV];
			BSEL_CPP: return dp_regs[REG_CPP];
			BSEL_TOS: return dp_regs[REG_TOS];
			BSEL_OPC: return dp_regs[REG_OPC];
			default: return '0;
		endcase
	endfunction

	// Runs one microinstruction on the shadow registers and returns what the block reports.
	function automatic result_t datapath_step(input item_t it);
		result_t r;
		logic [DATA_W-1:0] ain;
		logic [DATA_W-1:0] bin;
		logic [DATA_W-1:0] sum;
		logic [DATA_W-1:0] shifted;
		logic [DATA_W:0] wide;
		int i;
		r = '0;
		case (it.op)
			OP_LOAD: begin
				if (it.reg_index == REG_MBR)
					dp_mbr = it.load_value[MBR_W-1:0];
				else if (it.reg_index < REG_MBR)
					dp_regs[it.reg_index] = it.load_value;
			end
			OP_READ: begin
				if (it.reg_index == REG_MBR)
					r.read_value = {{(DATA_W-MBR_W){1'b0}}, dp_mbr};
				else if (it.reg_index < REG_MBR)
					r.read_value = dp_regs[it.reg_index];
			end
			OP_EXEC: begin
				if (it.shift_left8 && it.shift_right1) begin
					r.status = 1'b1;
				end else begin
					r.a_value = dp_regs[REG_H];
					r.b_value = b_source(it.b_select);
					ain = it.enable_a ? r.a_value : '0;
					bin = it.enable_b ? r.b_value : '0;
					if (it.invert_a)
						ain = ~ain;
					case (it.alu_func)
						ALU_AND: sum = (ain & bin) + DATA_W'(it.increment);
						ALU_OR: sum = (ain | bin) + DATA_W'(it.increment);
						ALU_NOTB: sum = ~bin + DATA_W'(it.increment);
						default: begin
							wide = {1'b0, ain} + {1'b0, bin} + (DATA_W+1)'(it.increment);
							sum = wide[DATA_W-1:0];
							r.flag_carry = wide[DATA_W];
						end
					endcase
					if (it.shift_left8)
						shifted = sum << 8;
					else if (it.shift_right1)
						shifted = {sum[DATA_W-1], sum[DATA_W-1:1]};
					else
						shifted = sum;
					for (i = 0; i < MASK_W; i++)
						if (it.c_mask[i])
							dp_regs[i] = shifted;
					r.alu_result = sum;
					r.shift_result = shifted;
					r.flag_n = shifted[DATA_W-1];
					r.flag_z = (shifted == '0);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic item_t exec_item(input logic sl, input logic sr, input logic [1:0] func,
		input logic ena, input logic enb, input logic inva, input logic inc,
		input logic [MASK_W-1:0] cmask, input logic [3:0] bsel);
		item_t it;
		it = '0;
		it.op = OP_EXEC;
		it.shift_left8 = sl;
		it.shift_right1 = sr;
		it.alu_func = func;
		it.enable_a = ena;
		it.enable_b = enb;
		it.invert_a = inva;
		it.increment = inc;
		it.c_mask = cmask;
		it.b_select = bsel;
		return it;
	endfunction

	function automatic item_t load_item(input logic [3:0] idx, input logic [DATA_W-1:0] value);
		item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.reg_index = idx;
		it.load_value = value;
		return it;
	endfunction

	function automatic item_t read_item(input logic [3:0] idx);
		item_t it;
		it = '0;
		it.op = OP_READ;
		it.reg_index = idx;
		return it;
	endfunction

	function automatic result_t read_result(input logic [DATA_W-1:0] value);
		result_t r;
		r = '0;
		r.read_value = value;
		return r;
	endfunction

	function automatic item_t random_item();
		item_t it;
		logic [63:0] bits;
		int pick;
		bits = {$urandom(), $urandom()};
		it = bits[$bits(item_t)-1:0];
		pick = $urandom_range(99);
		if (pick < 60)
			it.op = OP_EXEC;
		else if (pick < 75)
			it.op = OP_LOAD;
		else if (pick < 95)
			it.op = OP_READ;
		else
			it.op = OP_UNUSED;
		// Most microinstructions are valid, so keep the double shift rare.
		if (it.shift_left8 && it.shift_right1 && $urandom_range(9) != 0) begin
			if ($urandom_range(1))
				it.shift_left8 = 1'b0;
			else
				it.shift_right1 = 1'b0;
		end
		if ($urandom_range(99) < 80)
			it.b_select = 4'($urandom_range(8));
		if ($urandom_range(99) < 85)
			it.reg_index = 4'($urandom_range(9));
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: it.load_value = 32'h0000_0000;
				1: it.load_value = 32'hFFFF_FFFF;
				2: it.load_value = 32'h8000_0000;
				default: it.load_value = 32'h7FFF_FFFF;
			endcase
		end
		return it;
	endfunction

	task automatic add_known(input item_t it, input result_t want);
		stim_row_t row;
		row.it = it;
		row.known = 1'b1;
		row.want = want;
		stim_rows.push_back(row);
	endtask

	task automatic add_checked(input item_t it);
		stim_row_t row;
		row.it = it;
		row.known = 1'b0;
		row.want = '0;
		stim_rows.push_back(row);
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] result %0d: %s", $realtime, results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string field, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", field, got, want));
	endtask

	task automatic check_output();
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result transaction with no expectation pending");
		end else begin
			want = expected_results.pop_front();
			check_field("status", DATA_W'(m_axis_tuser[0]), DATA_W'(want.status));
			check_field("a_value", m_axis_tdata[31:0], want.a_value);
			check_field("b_value", m_axis_tdata[63:32], want.b_value);
			check_field("alu_result", m_axis_tdata[95:64], want.alu_result);
			check_field("shift_result", m_axis_tdata[127:96], want.shift_result);
			check_field("flag_n", DATA_W'(m_axis_tdata[128]), DATA_W'(want.flag_n));
			check_field("flag_z", DATA_W'(m_axis_tdata[129]), DATA_W'(want.flag_z));
			check_field("flag_carry", DATA_W'(m_axis_tdata[130]), DATA_W'(want.flag_carry));
			check_field("read_value", m_axis_tdata[162:131], want.read_value);
		end
		results_seen++;
	endtask

	initial begin
		item_t it;
		result_t predicted;
		result_t status_only;
		int sent;
		int i;
		bit quiet;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		for (i = 0; i < MASK_W; i++)
			dp_regs[i] = '0;
		dp_mbr = '0;

		status_only = '0;
		status_only.status = 1'b1;

		// Directed part: reset values, extremes, ignored codes, then every ALU function,
		// both shifts, MBR extension and carry out.
		add_known(read_item(REG_H), read_result(32'h0));
		add_known(read_item(REG_MBR), read_result(32'h0));
		add_checked(exec_item(1'b0, 1'b0, ALU_ADD, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, BSEL_MDR));
		add_known(load_item(REG_H, 32'h7FFF_FFFF), '0);
		add_known(load_item(REG_MDR, 32'h8000_0000), '0);
		add_known(load_item(REG_MBR, 32'hFFFF_FF80), '0);
		add_known(read_item(REG_MBR), read_result(32'h0000_0080));
		add_known(read_item(REG_NONE), read_result(32'h0));
		add_known(load_item(REG_NONE, 32'hDEAD_BEEF), '0);
		it = '1;
		it.op = OP_UNUSED;
		add_known(it, '0);
		add_known(exec_item(1'b1, 1'b1, ALU_ADD, 1'b1, 1'b1, 1'b1, 1'b1, 9'h1FF, BSEL_MDR),
			status_only);
		add_known(read_item(REG_H), read_result(32'h7FFF_FFFF));
		add_checked(exec_item(1'b0, 1'b0, ALU_ADD, 1'b1, 1'b1, 1'b0, 1'b1, 9'h004, BSEL_MDR));
		add_checked(exec_item(1'b0, 1'b0, ALU_AND, 1'b1, 1'b1, 1'b0, 1'b0, 9'h008, BSEL_MBR_S));
		add_checked(exec_item(1'b1, 1'b0, ALU_OR, 1'b1, 1'b1, 1'b0, 1'b0, 9'h010, BSEL_MBR_U));
		add_checked(exec_item(1'b0, 1'b1, ALU_NOTB, 1'b1, 1'b1, 1'b0, 1'b0, 9'h020, BSEL_PC));
		add_checked(exec_item(1'b0, 1'b0, ALU_ADD, 1'b1, 1'b1, 1'b1, 1'b0, 9'h040, BSEL_SP));
		add_known(load_item(REG_H, 32'hFFFF_FFFF), '0);
		add_checked(exec_item(1'b0, 1'b0, ALU_ADD, 1'b1, 1'b1, 1'b0, 1'b1, 9'h080, BSEL_MDR));
		add_checked(exec_item(1'b0, 1'b0, ALU_AND, 1'b1, 1'b1, 1'b0, 1'b0, 9'h001, BSEL_NONE));
		add_checked(exec_item(1'b0, 1'b0, ALU_NOTB, 1'b0, 1'b0, 1'b0, 1'b1, 9'h000, BSEL_MDR));
		add_checked(exec_item(1'b1, 1'b0, ALU_ADD, 1'b1, 1'b1, 1'b0, 1'b0, 9'h1FF, BSEL_OPC));
		add_checked(exec_item(1'b0, 1'b1, ALU_OR, 1'b1, 1'b1, 1'b0, 1'b0, 9'h100, BSEL_TOS));
		add_checked(exec_item(1'b0, 1'b0, ALU_ADD, 1'b1, 1'b1, 1'b0, 1'b1, 9'h002, BSEL_CPP));
		add_checked(exec_item(1'b0, 1'b0, ALU_OR, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, BSEL_LV));
		add_checked(read_item(REG_MAR));
		for (i = 0; i < RANDOM_ITEMS; i++)
			add_checked(random_item());

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		sent = 0;
		while (sent < stim_rows.size() || expected_results.size() != 0) begin
			@(posedge clk);
			quiet = (sent >= 300) && (sent < 450);
			if (m_axis_tvalid && m_axis_tready)
				check_output();
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = datapath_step(stim_rows[sent].it);
				expected_results.push_back(stim_rows[sent].known ?
					stim_rows[sent].want : predicted);
				sent++;
			end
			// A pending transaction holds its data until it is taken.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sent < stim_rows.size() &&
					(quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= item_data(stim_rows[sent].it);
					s_axis_tuser <= stim_rows[sent].it.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
		end

		repeat (DRAIN_CYCLES) begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_output();
			m_axis_tready <= 1'b1;
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
